// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk_i, switched off while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion on clk_i that also holds across reset.
`define ASSERT_CLK_NR(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: sv/lbnc_pkg.sv
// ----------------------------------------------------------------------------
// lbnc_pkg
// Shared types and constants of the Lucas binomial nonzero check.
// ----------------------------------------------------------------------------
package lbnc_pkg;

  localparam int unsigned LBNC_VALUE_BITS     = 64;  // width of n and k fields
  localparam int unsigned LBNC_BASE_BITS      = 8;   // width of the base field
  localparam int unsigned LBNC_VALUE_WIDTH    = 64;  // default of VALUE_WIDTH
  localparam int unsigned LBNC_BITS_PER_CYCLE = 8;   // quotient bits per cycle
  localparam logic [LBNC_BASE_BITS-1:0] LBNC_MIN_BASE = 8'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_COMPARE,
    ST_FINISH
  } lbnc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new item
    logic step;     // one divider step on n and k
    logic restart;  // clear remainders and chunk counter for the next digit
  } lbnc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;     // divider is on the final chunk of a digit
    logic bad;      // digit of k exceeds digit of n
    logic zero;     // both n and k are exhausted
  } lbnc_stat_t;

endpackage

// File: sv/lbnc_in_if.sv
// ----------------------------------------------------------------------------
// lbnc_in_if
// Input channel: valid/ready handshake with n, k and the base.
// ----------------------------------------------------------------------------
interface lbnc_in_if import lbnc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [LBNC_VALUE_BITS-1:0] top_value;
  logic [LBNC_VALUE_BITS-1:0] choose_value;
  logic [LBNC_BASE_BITS-1:0]  prime_base;

  modport source (output valid, output top_value, output choose_value,
                  output prime_base, input ready);
  modport sink   (input valid, input top_value, input choose_value,
                  input prime_base, output ready);
endinterface

// File: sv/lbnc_out_if.sv
// ----------------------------------------------------------------------------
// lbnc_out_if
// Output channel: valid/ready handshake with the one-bit answer.
// ----------------------------------------------------------------------------
interface lbnc_out_if ();
  logic valid;
  logic ready;
  logic is_nonzero;

  modport source (output valid, output is_nonzero, input ready);
  modport sink   (input valid, input is_nonzero, output ready);
endinterface

// File: sv/lbnc_ctrl.sv
// ----------------------------------------------------------------------------
// lbnc_ctrl
// Controller: sequences the digit divisions and holds the output register.
// ----------------------------------------------------------------------------
module lbnc_ctrl import lbnc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic       out_is_nonzero_o,
  output lbnc_cmd_t  cmd_o,
  input  lbnc_stat_t stat_i
);

  lbnc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_COMPARE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.step = 1'b1;
        if (stat_i.last) begin
          state_d = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (stat_i.bad || stat_i.zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.restart = 1'b1;
          state_d       = ST_DIVIDE;
        end
      end
      ST_FINISH: begin
        // The answer waits here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          res_d       = !stat_i.bad;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign out_is_nonzero_o = res_q;

endmodule

// File: sv/lbnc_datapath.sv
// ----------------------------------------------------------------------------
// lbnc_datapath
// Datapath: divides n and k by the base, several quotient bits a cycle,
// and compares the resulting digits.
// ----------------------------------------------------------------------------
module lbnc_datapath import lbnc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = LBNC_VALUE_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lbnc_cmd_t                  cmd_i,
  input  logic [LBNC_VALUE_BITS-1:0] top_value_i,
  input  logic [LBNC_VALUE_BITS-1:0] choose_value_i,
  input  logic [LBNC_BASE_BITS-1:0]  prime_base_i,
  output lbnc_stat_t                 stat_o
);

  localparam int unsigned SB     = LBNC_BITS_PER_CYCLE;
  localparam int unsigned CHUNKS = (VALUE_WIDTH + SB - 1) / SB;
  localparam int unsigned PW     = CHUNKS * SB;
  localparam int unsigned CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned RW     = LBNC_BASE_BITS;

  logic [PW-1:0] n_q, n_d, k_q, k_d;
  logic [RW-1:0] rn_q, rn_d, rk_q, rk_d;
  logic [RW-1:0] p_q, p_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SB+RW-1:0] div_n, div_k;

  // Restoring division of one chunk: remainder in, quotient bits and
  // remainder out. The remainder always stays below the base.
  function automatic logic [SB+RW-1:0] div_chunk(input logic [RW-1:0] r_in,
                                                 input logic [SB-1:0] bits,
                                                 input logic [RW-1:0] base);
    logic [RW:0]   t;
    logic [RW-1:0] r;
    logic [SB-1:0] q;
    r = r_in;
    q = '0;
    for (int i = SB - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, base}) begin
        t    = t - {1'b0, base};
        q[i] = 1'b1;
      end
      r = t[RW-1:0];
    end
    return {q, r};
  endfunction

  assign div_n = div_chunk(rn_q, n_q[PW-1 -: SB], p_q);
  assign div_k = div_chunk(rk_q, k_q[PW-1 -: SB], p_q);

  always_comb begin
    n_d   = n_q;
    k_d   = k_q;
    rn_d  = rn_q;
    rk_d  = rk_q;
    p_d   = p_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      n_d   = PW'(top_value_i[VALUE_WIDTH-1:0]);
      k_d   = PW'(choose_value_i[VALUE_WIDTH-1:0]);
      p_d   = (prime_base_i < LBNC_MIN_BASE) ? LBNC_MIN_BASE : prime_base_i;
      rn_d  = '0;
      rk_d  = '0;
      cnt_d = '0;
    end else if (cmd_i.restart) begin
      rn_d  = '0;
      rk_d  = '0;
      cnt_d = '0;
    end else if (cmd_i.step) begin
      // Quotient bits enter at the bottom as the dividend leaves the top.
      n_d   = (n_q << SB) | PW'(div_n[SB+RW-1:RW]);
      k_d   = (k_q << SB) | PW'(div_k[SB+RW-1:RW]);
      rn_d  = div_n[RW-1:0];
      rk_d  = div_k[RW-1:0];
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    k_q  <= k_d;
    rn_q <= rn_d;
    rk_q <= rk_d;
    p_q  <= p_d;
  end

  assign stat_o.last = (cnt_q == CW'(CHUNKS - 1));
  assign stat_o.bad  = (rk_q > rn_q);
  assign stat_o.zero = (n_q == '0) && (k_q == '0);

endmodule

// File: sv/lucas_binomial_nonzero_check.sv
// The controller walks the base-p digits of n and k from the least significant one, up to the
// first failing digit or until n and k are used up; each digit is a pass of the 8-bit-per-cycle
// divider followed by a compare. One transaction is processed at a time; a finished result waits
// in the output register while the next transaction is accepted. Reset clears the controller
// state, the output valid flag and the datapath chunk counter.
// ----------------------------------------------------------------------------
// lucas_binomial_nonzero_check
// Decides whether C(n,k) is nonzero modulo p by comparing base-p digits.
// ----------------------------------------------------------------------------
module lucas_binomial_nonzero_check import lbnc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = LBNC_VALUE_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lbnc_in_if.sink           in_i,
  lbnc_out_if.source        out_o
);

  lbnc_cmd_t  cmd;
  lbnc_stat_t stat;

  lbnc_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_is_nonzero_o (out_o.is_nonzero),
    .cmd_o            (cmd),
    .stat_i           (stat)
  );

  lbnc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .top_value_i    (in_i.top_value),
    .choose_value_i (in_i.choose_value),
    .prime_base_i   (in_i.prime_base),
    .stat_o         (stat)
  );

endmodule

// File: sv/lbnc_checker.sv
// ----------------------------------------------------------------------------
// lbnc_checker
// Port-level checks of the Lucas binomial nonzero check.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbnc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_nonzero
);

  // A stalled result keeps its value.
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_is_nonzero), "stalled result changed")

  // Only one transaction is in work, so the input closes after an acceptance.
  `ASSERT_CLK(a_one_in_work, in_valid && in_ready |=> !in_ready, "input accepted twice in a row")

  // No result appears in the cycle straight after an acceptance.
  `ASSERT_CLK(a_min_latency, in_valid && in_ready |=> !$rose(out_valid), "result too early")

  // Leaving reset, no result is pending.
  `ASSERT_CLK_NR(a_reset_empty, $rose(rst_ni) |-> !out_valid, "result valid after reset")

endmodule

bind lucas_binomial_nonzero_check lbnc_checker u_lbnc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .out_is_nonzero (out_o.is_nonzero)
);

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Lucas binomial nonzero check. Items with digit-
// wise dominated, spoiled and random lower arguments are driven in bursts, the
// answer channel stalls at random, and each answer is compared in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbnc_pkg::*;

  localparam int unsigned VALUE_WIDTH  = LBNC_VALUE_WIDTH;
  localparam bit [63:0]   VALUE_MASK   = {64{1'b1}} >> (64 - VALUE_WIDTH);
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam bit [63:0]   ALL_ONES     = {64{1'b1}};
  localparam bit [63:0]   TOP_BIT      = 64'h8000_0000_0000_0000;

  typedef struct packed {
    bit [63:0] top;
    bit [63:0] choose;
    bit [7:0]  base;
    bit        nonzero;
  } lucas_answer_t;

  class lucas_answer_board;
    lucas_answer_t answers_due[$];
    int unsigned   mismatches;

    // Digit rule of Lucas' theorem, walking from the least significant digit.
    static function bit digits_fit(bit [63:0] top, bit [63:0] choose, bit [7:0] base);
      bit [63:0] radix;
      radix  = (base < LBNC_MIN_BASE) ? {56'd0, LBNC_MIN_BASE} : {56'd0, base};
      top    = top & VALUE_MASK;
      choose = choose & VALUE_MASK;
      while (top != 0 || choose != 0) begin
        if (choose % radix > top % radix) return 1'b0;
        top    = top / radix;
        choose = choose / radix;
      end
      return 1'b1;
    endfunction

    function void note_transaction(bit [63:0] top, bit [63:0] choose, bit [7:0] base);
      lucas_answer_t entry;
      entry.top     = top;
      entry.choose  = choose;
      entry.base    = base;
      entry.nonzero = digits_fit(top, choose, base);
      answers_due.push_back(entry);
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0t ns  mismatch: %s", $realtime, what);
    endtask

    task check_answer(logic got);
      lucas_answer_t entry;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("answer %b with no transaction outstanding", got));
      end else begin
        entry = answers_due.pop_front();
        if (got !== entry.nonzero) begin
          report_mismatch($sformatf("n=%h k=%h p=%0d: is_nonzero %b, wanted %b",
                                    entry.top, entry.choose, entry.base, got,
                                    entry.nonzero));
        end
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  lbnc_in_if  in_if ();
  lbnc_out_if out_if ();

  lucas_answer_board board;
  int unsigned       idle_cycles;

  lucas_binomial_nonzero_check #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #4 clk_i = ~clk_i;

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_item(input bit [63:0] top, input bit [63:0] choose,
                            input bit [7:0] base);
    in_if.valid        <= 1'b1;
    in_if.top_value    <= top;
    in_if.choose_value <= choose;
    in_if.prime_base   <= base;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_transaction(top, choose, base);
    @(negedge clk_i);
  endtask

  // Every caller passes a nonzero length, so valid is never lowered and raised in one step.
  task automatic pause_sender(input int unsigned cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Builds k digit by digit below the digits of n; with spoil set, one randomly picked digit
  // is pushed above its counterpart unless it is already radix - 1, so the walk fails there.
  function automatic bit [63:0] dominated_choose(bit [63:0] top, bit [63:0] radix,
                                                 bit spoil);
    bit [63:0]   rest;
    bit [63:0]   weight;
    bit [63:0]   choose;
    bit [63:0]   digit;
    bit [63:0]   pick_digit;
    int unsigned count;
    int unsigned pick;
    int unsigned idx;
    if (top == 0) return spoil ? 64'($urandom_range(1, 32'(radix - 1))) : 64'd0;
    rest  = top;
    count = 0;
    while (rest != 0) begin
      count++;
      rest = rest / radix;
    end
    pick   = $urandom_range(0, count - 1);
    rest   = top;
    weight = 64'd1;
    choose = 64'd0;
    idx    = 0;
    while (rest != 0) begin
      digit      = rest % radix;
      pick_digit = 64'($urandom_range(0, 32'(digit)));
      if (spoil && idx == pick && digit < radix - 1) begin
        pick_digit = digit + 64'($urandom_range(1, 32'(radix - 1 - digit)));
      end
      choose = choose + pick_digit * weight;
      rest   = rest / radix;
      weight = weight * radix;
      idx++;
    end
    return choose;
  endfunction

  task automatic make_random_item(output bit [63:0] top, output bit [63:0] choose,
                                  output bit [7:0] base);
    int unsigned roll;
    int unsigned width;
    bit [63:0]   radix;
    roll = $urandom_range(0, 99);
    if (roll < 3)       base = 8'($urandom_range(0, 1));
    else if (roll < 20) base = 8'($urandom_range(2, 7));
    else if (roll < 28) base = 8'($urandom_range(128, 255));
    else                base = 8'($urandom_range(2, 255));
    radix = (base < LBNC_MIN_BASE) ? {56'd0, LBNC_MIN_BASE} : {56'd0, base};
    // Small bases walk many digits, so their operands are mostly kept short.
    if (radix <= 3 && $urandom_range(0, 3) != 0) width = $urandom_range(0, 16);
    else                                          width = $urandom_range(0, 64);
    top = {$urandom, $urandom};
    if (width < 64) top = top & ((64'd1 << width) - 64'd1);
    roll = $urandom_range(0, 9);
    if (roll <= 5) begin
      choose = dominated_choose(top, radix, 1'b0);
    end else if (roll <= 7) begin
      choose = dominated_choose(top, radix, 1'b1);
    end else if (roll == 8) begin
      width  = $urandom_range(0, 64);
      choose = {$urandom, $urandom};
      if (width < 64) choose = choose & ((64'd1 << width) - 64'd1);
    end else begin
      case ($urandom_range(0, 2))
        0:       choose = top;
        1:       choose = top + 64'd1;
        default: choose = 64'd0;
      endcase
    end
  endtask

  initial begin
    bit [63:0]   top;
    bit [63:0]   choose;
    bit [7:0]    base;
    int unsigned sent;
    int unsigned burst;
    board                = new();
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.top_value      = '0;
    in_if.choose_value   = '0;
    in_if.prime_base     = LBNC_MIN_BASE;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Both zero, bases below two, all-ones operands, k above n, odd bases.
    offer_item(64'd0, 64'd0, 8'd2);
    offer_item(64'd0, 64'd0, 8'd0);
    offer_item(64'd0, 64'd0, 8'd1);
    offer_item(ALL_ONES, 64'd0, 8'd2);
    offer_item(ALL_ONES, ALL_ONES, 8'd2);
    offer_item(64'd0, ALL_ONES, 8'd2);
    offer_item(ALL_ONES, ALL_ONES - 64'd1, 8'd2);
    offer_item(ALL_ONES, TOP_BIT, 8'd2);
    offer_item(TOP_BIT, TOP_BIT, 8'd3);
    offer_item(TOP_BIT, 64'd1, 8'd1);
    offer_item(ALL_ONES, ALL_ONES, 8'd255);
    offer_item(64'd0, 64'd1, 8'd255);
    offer_item(64'd254, 64'd255, 8'd255);
    offer_item(64'd3, 64'd5, 8'd7);
    offer_item(64'd100, 64'd200, 8'd0);
    offer_item(64'd255, 64'd254, 8'd1);
    offer_item(64'd10, 64'd4, 8'd4);
    offer_item(64'd36, 64'd6, 8'd6);
    offer_item(ALL_ONES, ALL_ONES, 8'd128);
    offer_item(64'd1000, 64'd999, 8'd10);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      repeat (burst) begin
        make_random_item(top, choose, base);
        offer_item(top, choose, base);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 20));
    end
    pause_sender(1);

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // The answer side alternates between free flow, random stalls, long stalls
  // and a sparse ready pattern.
  initial begin
    int unsigned mode;
    int unsigned span;
    out_if.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      case (mode)
        0: begin
          repeat (span) begin
            @(negedge clk_i);
            out_if.ready <= 1'b1;
          end
        end
        1: begin
          repeat (span) begin
            @(negedge clk_i);
            out_if.ready <= 1'($urandom_range(0, 1));
          end
        end
        2: begin
          @(negedge clk_i);
          out_if.ready <= 1'b0;
          repeat ($urandom_range(1, 60)) @(negedge clk_i);
          out_if.ready <= 1'b1;
        end
        default: begin
          repeat (span) begin
            @(negedge clk_i);
            out_if.ready <= ($urandom_range(0, 3) == 0);
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) board.check_answer(out_if.is_nonzero);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule
